### rtl/core/assert_macros.svh
// Assertion helpers for the route table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### rtl/core/lpm_pkg.sv
`default_nettype none
package lpm_pkg;
  localparam int NODES    = 1024;
  localparam int NODE_W   = $clog2(NODES);
  localparam int GW_SLOTS = 8;
  localparam int GW_W     = $clog2(GW_SLOTS);
  localparam int MAX_LEN  = 32;
  localparam int TOP_BIT  = 31;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              mark;
    logic [15:0]       port;
  } node_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK, S_ADD_CHK, S_ALLOC_RD, S_ALLOC,
    S_MARK, S_DEL_CHK, S_PRUNE_RD, S_PRUNE, S_UNLINK, S_GW, S_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/core/lpm_binary_trie_route_table.sv
`default_nettype none
// Channel | Signals                                             | Direction
// in      | in_valid/in_ready, kind, dest_prefix, prefix_len,   | into block
//         | gw_route, gateway, port                             |
// out     | out_valid/out_ready, status, hit, out_port          | out of block
//
// After reset, a clearing pass fills the free-node stack and empties the
// root; no item is taken meanwhile. One node-memory port (one read or one
// write per cycle) walks the trie with a read state (WALK_RD) and a check
// state (WALK) per node: a lookup visits up to 33 levels, an add walks and
// then allocates each new node (ALLOC_RD, ALLOC), and a delete walks and
// then prunes level by level (PRUNE_RD, PRUNE, UNLINK). Gateway items pass
// through GW. The result moves to an output register; the next item is taken
// meanwhile and its result is held until that register is free.
module lpm_binary_trie_route_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] dest_prefix,
  input  wire logic [5:0]  prefix_len,
  input  wire logic        gw_route,
  input  wire logic [31:0] gateway,
  input  wire logic [15:0] port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             hit,
  output logic [15:0]      out_port
);
  import lpm_pkg::*;
  `include "assert_macros.svh"

  // node pool, free stack, delete path (path[i] is the node at level i+1)
  node_t             nodes  [NODES];
  logic [NODE_W-1:0] fstack [NODES];
  logic [NODE_W-1:0] path   [MAX_LEN];

  state_t state, state_next;

  logic [1:0]        r_kind;
  logic [31:0]       r_pfx;
  logic [5:0]        r_len;
  logic [31:0]       r_gwa;
  logic [15:0]       r_port;
  logic [5:0]        depth;
  logic [NODE_W-1:0] cur;
  node_t             cnode;
  logic [NODE_W:0]   fcount, fcount_next;
  node_t             rd;
  logic [NODE_W-1:0] fs_rd;
  logic              lk_hit;
  logic [15:0]       lk_port;
  logic [1:0]        res_status;
  logic              res_hit;
  logic [15:0]       res_port;

  // shared node port
  logic              n_we;
  logic [NODE_W-1:0] n_addr;
  node_t             n_wd;
  node_t             n_rd;

  logic              bit_d, bit_dm1;
  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] lvl_node, par_node;
  logic              prune_go;
  logic              res_load;
  logic [1:0]        gw_status;
  logic              gw_inc, gw_dec, gw_has;
  logic [15:0]       gw_hport;
  logic              gw_en;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = state == S_IDLE;
  assign bit_d    = r_pfx[5'(TOP_BIT) - depth[4:0]];
  assign bit_dm1  = r_pfx[5'(TOP_BIT) - 5'(depth - 6'd1)];
  assign child    = bit_d ? rd.right : rd.left;
  assign gw_en    = state == S_GW;
  // prune runs only at depth 1 and above; the parent of level 1 is the root
  assign lvl_node = path[5'(depth - 6'd1)];
  assign par_node = depth <= 6'd1 ? '0 : path[5'(depth - 6'd2)];
  assign prune_go = state == S_PRUNE && !rd.mark && rd.left == '0 && rd.right == '0;
  // move the result out once the output register is free
  assign res_load = state == S_DONE && (!out_valid || out_ready);

  lpm_gw_list u_gw (
    .clk(clk), .rst(rst), .op_en(gw_en), .op_del(r_kind == KIND_DEL),
    .gw_addr(r_gwa), .gw_port(r_port), .status(gw_status),
    .rt_inc(gw_inc), .rt_dec(gw_dec), .has_head(gw_has), .head_port(gw_hport)
  );

  always_ff @(posedge clk) begin
    if (n_we) nodes[n_addr] <= n_wd;
    n_rd <= nodes[n_addr];
  end
  assign rd = n_rd;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:     if (fcount == (NODE_W+1)'(NODES-1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_RSVD) state_next = S_DONE;
          else if (gw_route && kind != KIND_LOOKUP) state_next = S_GW;
          else state_next = S_WALK_RD;
        end
      end
      S_WALK_RD:  state_next = S_WALK;
      S_WALK: begin
        if (r_kind == KIND_LOOKUP) begin
          if (depth == 6'd32 || child == '0) state_next = S_DONE;
          else state_next = S_WALK_RD;
        end else if (depth == r_len) begin
          state_next = r_kind == KIND_ADD ? S_ADD_CHK : S_DEL_CHK;
        end else if (child == '0) begin
          state_next = r_kind == KIND_ADD ? S_ADD_CHK : S_DONE;
        end else state_next = S_WALK_RD;
      end
      S_ADD_CHK: begin
        if (depth == r_len && rd.mark) state_next = S_DONE;
        else if ((NODE_W+1)'(r_len - depth) > fcount) state_next = S_DONE;
        else if (depth == r_len) state_next = S_MARK;
        else state_next = S_ALLOC_RD;
      end
      S_ALLOC_RD: state_next = S_ALLOC;
      S_ALLOC:    state_next = (depth + 6'd1 == r_len) ? S_MARK : S_ALLOC_RD;
      S_MARK:     state_next = S_DONE;
      S_DEL_CHK:  state_next = (rd.mark && r_len != '0) ? S_PRUNE_RD : S_DONE;
      S_PRUNE_RD: state_next = S_PRUNE;
      S_PRUNE:    state_next = prune_go ? S_UNLINK : S_DONE;
      S_UNLINK:   state_next = depth == 6'd1 ? S_DONE : S_PRUNE_RD;
      S_GW:       state_next = S_DONE;
      S_DONE:     state_next = res_load ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // node port control: clear root during init, zero a new node at ALLOC_RD,
  // link it from its parent at ALLOC, set or clear the mark at MARK/DEL_CHK,
  // read the parent at PRUNE and drop the link to the pruned child at UNLINK
  always_comb begin
    n_we   = 1'b0;
    n_addr = cur;
    n_wd   = cnode;
    unique case (state)
      S_INIT: begin
        n_we = 1'b1; n_addr = '0; n_wd = '0;
      end
      S_ALLOC_RD: begin
        n_we = 1'b1; n_addr = fs_rd; n_wd = '0;
      end
      S_ALLOC: begin
        n_we = 1'b1;
        n_wd = cnode;
        if (bit_d) n_wd.right = fs_rd; else n_wd.left = fs_rd;
      end
      S_MARK: begin
        n_we = 1'b1; n_wd = cnode; n_wd.mark = 1'b1; n_wd.port = r_port;
      end
      S_DEL_CHK: begin
        n_we = rd.mark; n_wd = rd; n_wd.mark = 1'b0; n_wd.port = '0;
      end
      S_PRUNE_RD: n_addr = lvl_node;
      S_PRUNE:    n_addr = par_node;
      S_UNLINK: begin
        n_we = 1'b1;
        n_addr = par_node;
        n_wd = rd;
        if (bit_dm1) n_wd.right = '0; else n_wd.left = '0;
      end
      default: n_addr = cur;
    endcase
  end

  // free count: fill during init, pop on allocation, push on prune
  always_comb begin
    fcount_next = fcount;
    if (state == S_INIT && fcount != (NODE_W+1)'(NODES-1)) fcount_next = fcount + 1'b1;
    else if (state == S_ALLOC) fcount_next = fcount - 1'b1;
    else if (prune_go && fcount < (NODE_W+1)'(NODES)) fcount_next = fcount + 1'b1;
  end

  // free stack; the top entry is read ahead using the next count
  always_ff @(posedge clk) begin
    if (state == S_INIT) fstack[fcount[NODE_W-1:0]] <= NODE_W'(NODES-1) - fcount[NODE_W-1:0];
    else if (prune_go && fcount < (NODE_W+1)'(NODES))
      fstack[fcount[NODE_W-1:0]] <= lvl_node;
    fs_rd <= fstack[NODE_W'(fcount_next - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK && r_kind == KIND_DEL && depth != r_len && child != '0)
      path[depth[4:0]] <= child;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      fcount <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      fcount <= fcount_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= res_status; hit <= res_hit; out_port <= res_port;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind <= kind; r_pfx <= dest_prefix;
      r_len  <= prefix_len > 6'd32 ? 6'd32 : prefix_len;
      r_gwa <= gateway; r_port <= port;
      depth <= '0; cur <= '0; lk_hit <= 1'b0; lk_port <= '0;
      res_status <= ST_OK; res_hit <= 1'b0; res_port <= '0;
    end
    unique case (state)
      S_WALK: begin
        if (rd.mark) begin lk_hit <= 1'b1; lk_port <= rd.port; end
        if (r_kind == KIND_LOOKUP) begin
          if (depth != 6'd32 && child != '0) begin cur <= child; depth <= depth + 6'd1; end
        end else if (depth != r_len && child != '0) begin
          cur <= child; depth <= depth + 6'd1;
        end
        if (r_kind == KIND_LOOKUP && (depth == 6'd32 || child == '0)) begin
          if (rd.mark) begin
            res_hit <= 1'b1; res_port <= rd.port; res_status <= ST_OK;
          end else if (lk_hit) begin
            res_hit <= 1'b1; res_port <= lk_port; res_status <= ST_OK;
          end else if (gw_has) begin
            res_hit <= 1'b1; res_port <= gw_hport; res_status <= ST_OK;
          end else res_status <= ST_NOT_FOUND;
        end
        if (r_kind == KIND_DEL && depth != r_len && child == '0) res_status <= ST_NOT_FOUND;
      end
      S_ADD_CHK: begin
        cnode <= rd;
        if (depth == r_len && rd.mark) res_status <= ST_EXISTS;
        else if ((NODE_W+1)'(r_len - depth) > fcount) res_status <= ST_NO_SPACE;
      end
      S_ALLOC: begin cur <= fs_rd; depth <= depth + 6'd1; cnode <= '0; end
      S_DEL_CHK: if (!rd.mark) res_status <= ST_NOT_FOUND;
      S_UNLINK: depth <= depth - 6'd1;
      S_GW: res_status <= gw_status;
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")
  `ASSERT_IMPL(a_fcount, clk, rst, 1'b1, fcount <= (NODE_W+1)'(NODES), "free count over")
  `ASSERT_NEXT(a_done_out, clk, rst, state == S_DONE, out_valid, "result lost")
  `ASSERT_IMPL(a_depth, clk, rst, state != S_INIT && state != S_IDLE, depth <= 6'd32, "depth over")
  `ASSERT_IMPL(a_gw_step, clk, rst, !gw_en, !gw_inc && !gw_dec, "gateway list changed")
endmodule
`default_nettype wire

### rtl/core/lpm_gw_list.sv
`default_nettype none
module lpm_gw_list (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     op_en,
  input  wire logic                     op_del,
  input  wire logic [31:0]              gw_addr,
  input  wire logic [15:0]              gw_port,
  output logic [1:0]                    status,
  output logic                          rt_inc,
  output logic                          rt_dec,
  output logic                          has_head,
  output logic [15:0]                   head_port
);
  import lpm_pkg::*;
  `include "assert_macros.svh"

  logic [31:0] addr [GW_SLOTS];
  logic [15:0] prt  [GW_SLOTS];
  logic [GW_W:0] count;
  logic [GW_SLOTS-1:0] match;
  logic [GW_W-1:0] idx;
  logic found;

  always_comb begin
    match = '0;
    for (int i = 0; i < GW_SLOTS; i++)
      match[i] = (GW_W+1)'(i) < count && addr[i] == gw_addr;
    found = |match;
    idx = '0;
    for (int i = GW_SLOTS-1; i >= 0; i--)
      if (match[i]) idx = GW_W'(i);
    if (op_del) status = found ? ST_OK : ST_NOT_FOUND;
    else if (found) status = ST_EXISTS;
    else if (count == (GW_W+1)'(GW_SLOTS)) status = ST_NO_SPACE;
    else status = ST_OK;
    rt_inc = op_en && !op_del && status == ST_OK;
    rt_dec = op_en && op_del && status == ST_OK;
  end

  assign has_head  = count != '0;
  assign head_port = prt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (rt_inc) begin
      count <= count + 1'b1;
    end else if (rt_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rt_inc) begin
      for (int i = GW_SLOTS-1; i > 0; i--) begin
        addr[i] <= addr[i-1];
        prt[i]  <= prt[i-1];
      end
      addr[0] <= gw_addr;
      prt[0]  <= gw_port;
    end else if (rt_dec) begin
      for (int i = 0; i < GW_SLOTS-1; i++)
        if (GW_W'(i) >= idx) begin
          addr[i] <= addr[i+1];
          prt[i]  <= prt[i+1];
        end
    end
  end

  `ASSERT_IMPL(a_gw_cnt_max, clk, rst, 1'b1, count <= (GW_W+1)'(GW_SLOTS), "gateway count over")
  `ASSERT_IMPL(a_gw_excl, clk, rst, 1'b1, !(rt_inc && rt_dec), "gateway inc and dec")
  `ASSERT_NEXT(a_gw_head, clk, rst, rt_inc, has_head, "gateway add left list empty")
endmodule
`default_nettype wire
